// ===== design/mcfd_pkg.sv =====
// Shared types and constants for the motor command frame decoder.
`default_nettype none

package mcfd_pkg;

    localparam logic [10:0] NODE_ID_RESET = 11'h123;
    localparam logic [3:0]  FRAME_LEN     = 4'd8;
    localparam logic [7:0]  TERMINATOR    = 8'h0A;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_K = 8'h4B;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_O = 8'h4F;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_Q = 8'h51;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_U = 8'h55;
    localparam logic [7:0] CH_V = 8'h56;

    typedef enum logic [2:0] {
        ACT_REJECT   = 3'd0,
        ACT_NONE     = 3'd1,
        ACT_DRIVE    = 3'd2,
        ACT_SETPOINT = 3'd3,
        ACT_GAIN     = 3'd4,
        ACT_REPLY    = 3'd5
    } t_action;

    localparam logic [2:0] PSEL_SETPOINT = 3'd0;
    localparam logic [2:0] PSEL_KP       = 3'd1;
    localparam logic [2:0] PSEL_KI       = 3'd2;
    localparam logic [2:0] PSEL_KD       = 3'd3;
    localparam logic [2:0] PSEL_GE       = 3'd4;
    localparam logic [2:0] PSEL_GDE      = 3'd5;
    localparam logic [2:0] PSEL_GDU      = 3'd6;

    localparam logic [2:0] RSEL_SPEED    = 3'd0;
    localparam logic [2:0] RSEL_CHIP_T   = 3'd1;
    localparam logic [2:0] RSEL_SENSOR_T = 3'd2;
    localparam logic [2:0] RSEL_CURRENT  = 3'd3;
    localparam logic [2:0] RSEL_DUTY     = 3'd4;
    localparam logic [2:0] RSEL_SETPOINT = 3'd5;

    typedef struct packed {
        logic            mode;
        logic [10:0]     frame_id;
        logic            extended;
        logic [3:0]      length;
        logic [7:0][7:0] data;
    } t_item;

    typedef struct packed {
        logic link;
        logic open_loop;
        logic pid;
        logic fuzzy;
        logic cw;
        logic ccw;
    } t_flags;

    typedef struct packed {
        t_action     action;
        logic [2:0]  param_select;
        logic        direction;
        logic [31:0] value;
        logic [2:0]  reply_select;
        logic        all;
        t_flags      flags;
    } t_result;

    // Reply order of a request for all telemetry values.
    function automatic logic [2:0] all_reply_sel(input logic [1:0] idx);
        logic [2:0] sel;
        case (idx)
            2'd0:    sel = RSEL_SPEED;
            2'd1:    sel = RSEL_SENSOR_T;
            2'd2:    sel = RSEL_CURRENT;
            default: sel = RSEL_DUTY;
        endcase
        return sel;
    endfunction

endpackage

`default_nettype wire

// ===== design/mcfd_decode.sv =====
// Single-pass command decoder: frame checks, command words and flag update.
`default_nettype none

module mcfd_decode (
    input  mcfd_pkg::t_item   i_item,
    input  mcfd_pkg::t_flags  i_flags,
    input  logic [10:0]       i_node_id,
    output mcfd_pkg::t_result o_result,
    output mcfd_pkg::t_flags  o_flags
);
    import mcfd_pkg::*;

    logic [7:0]  b0, b1, b2, b3, b4, b5, b6;
    logic [7:0]  sum;
    logic        frame_ok;
    logic        link_n;
    logic        is_ol, is_cl, want_pid, dir_ccw, ok;
    logic [2:0]  gain_sel;
    logic        is_req;
    logic [31:0] val;
    t_flags      fl;
    t_result     res;

    assign b0 = i_item.data[0];
    assign b1 = i_item.data[1];
    assign b2 = i_item.data[2];
    assign b3 = i_item.data[3];
    assign b4 = i_item.data[4];
    assign b5 = i_item.data[5];
    assign b6 = i_item.data[6];

    // The checksum byte is correct exactly when all eight bytes sum to zero.
    assign sum = b0 + b1 + b2 + b3 + b4 + b5 + b6 + i_item.data[7];
    assign frame_ok = (i_item.frame_id == i_node_id) && !i_item.extended &&
                      (i_item.length == FRAME_LEN) && (sum == 8'd0);
    assign val = {b6, b5, b4, b3};

    assign is_ol    = (b0 == CH_O) && (b1 == CH_L) && ((b2 == CH_R) || (b2 == CH_L));
    assign is_cl    = (b0 == CH_C) && ((b1 == CH_P) || (b1 == CH_F)) &&
                      ((b2 == CH_R) || (b2 == CH_L));
    assign want_pid = (b1 == CH_P);
    assign dir_ccw  = (b2 == CH_L);
    assign is_req   = (b0 == CH_R) && (b1 == CH_E) && (b2 == CH_Q) && (b6 == TERMINATOR);

    always_comb begin
        gain_sel = 3'd0;
        if (b0 == CH_G) begin
            if (b1 == CH_K && b2 == CH_P)      gain_sel = PSEL_KP;
            else if (b1 == CH_K && b2 == CH_I) gain_sel = PSEL_KI;
            else if (b1 == CH_K && b2 == CH_D) gain_sel = PSEL_KD;
            else if (b1 == CH_G && b2 == CH_E) gain_sel = PSEL_GE;
            else if (b1 == CH_D && b2 == CH_E) gain_sel = PSEL_GDE;
            else if (b1 == CH_D && b2 == CH_U) gain_sel = PSEL_GDU;
        end
    end

    always_comb begin
        link_n = i_flags.link;
        if (b0 == CH_C && b1 == CH_A && b2 == CH_N) begin
            if (b3 == CH_O)      link_n = 1'b1;
            else if (b3 == CH_C) link_n = 1'b0;
        end
    end

    always_comb begin
        fl  = i_flags;
        ok  = 1'b0;
        res = '0;
        res.action = ACT_NONE;
        if (i_item.mode) begin
            fl.open_loop = 1'b0;
            fl.pid       = 1'b0;
            fl.fuzzy     = 1'b0;
            fl.cw        = 1'b0;
            fl.ccw       = 1'b0;
        end else if (!frame_ok) begin
            res.action = ACT_REJECT;
        end else begin
            fl.link = link_n;
            if (!link_n) begin
                res.action = ACT_NONE;
            end else if (is_ol) begin
                fl.cw  = !dir_ccw;
                fl.ccw = dir_ccw;
                if (!i_flags.pid && !i_flags.fuzzy) begin
                    fl.open_loop  = 1'b1;
                    res.action    = ACT_DRIVE;
                    res.direction = dir_ccw;
                    res.value     = val;
                end
            end else if (is_cl) begin
                fl.cw  = !dir_ccw;
                fl.ccw = dir_ccw;
                if (want_pid) begin
                    ok = !i_flags.open_loop && !i_flags.fuzzy;
                    if (ok) fl.pid = 1'b1;
                end else begin
                    ok = !i_flags.open_loop && !i_flags.pid;
                    if (ok) fl.fuzzy = 1'b1;
                end
                if (ok) begin
                    res.action       = ACT_SETPOINT;
                    res.param_select = PSEL_SETPOINT;
                    res.direction    = dir_ccw;
                    res.value        = val;
                end
            end else if (gain_sel != 3'd0) begin
                res.action       = ACT_GAIN;
                res.param_select = gain_sel;
                res.value        = val;
            end else if (is_req) begin
                res.action = ACT_REPLY;
                if (b3 == CH_A && b4 == CH_L && b5 == CH_L)
                    res.all = 1'b1;
                else if (b3 == CH_R && b4 == CH_P && b5 == CH_V)
                    res.reply_select = RSEL_SPEED;
                else if (b3 == CH_A && b4 == CH_O && b5 == CH_C)
                    res.reply_select = RSEL_CHIP_T;
                else if (b3 == CH_A && b4 == CH_T && b5 == CH_K)
                    res.reply_select = RSEL_SENSOR_T;
                else if (b3 == CH_A && b4 == CH_I && b5 == CH_M)
                    res.reply_select = RSEL_CURRENT;
                else if (b3 == CH_T && b4 == CH_D && b5 == CH_C)
                    res.reply_select = RSEL_DUTY;
                else if (b3 == CH_R && b4 == CH_S && b5 == CH_P)
                    res.reply_select = RSEL_SETPOINT;
                else
                    res.action = ACT_NONE;
            end
        end
        res.flags = fl;
    end

    assign o_result = res;
    assign o_flags  = fl;

endmodule

`default_nettype wire

// ===== design/mcfd_out.sv =====
// Result register that also steps through the four replies of a request for all values.
`default_nettype none

module mcfd_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mcfd_pkg::t_result i_result,
    output logic              o_load_ok,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_action,
    output logic [2:0]        o_param_select,
    output logic              o_direction,
    output logic [31:0]       o_value,
    output logic [2:0]        o_reply_select,
    output logic              o_link_enabled,
    output logic              o_open_loop_on,
    output logic              o_pid_on,
    output logic              o_fuzzy_on,
    output logic              o_run_cw,
    output logic              o_run_ccw,
    output logic              o_last
);
    import mcfd_pkg::*;

    t_result    r_res;
    logic       r_valid;
    logic [1:0] r_idx;
    logic       last;

    assign last      = !r_res.all || (r_idx == 2'd3);
    assign o_load_ok = !r_valid || (i_ready && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (r_valid && i_ready) begin
            r_valid <= !last;
            r_idx   <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_valid        = r_valid;
    assign o_action       = r_res.action;
    assign o_param_select = r_res.param_select;
    assign o_direction    = r_res.direction;
    assign o_value        = r_res.value;
    assign o_reply_select = r_res.all ? all_reply_sel(r_idx) : r_res.reply_select;
    assign o_link_enabled = r_res.flags.link;
    assign o_open_loop_on = r_res.flags.open_loop;
    assign o_pid_on       = r_res.flags.pid;
    assign o_fuzzy_on     = r_res.flags.fuzzy;
    assign o_run_cw       = r_res.flags.cw;
    assign o_run_ccw      = r_res.flags.ccw;
    assign o_last         = last;

endmodule

`default_nettype wire

// ===== design/motor_command_frame_decoder.sv =====
// Top level of the motor command frame decoder.
//
//   Channel   Handshake            Contents
//   request   i_valid / o_ready    mode, frame id, extended, length, eight payload bytes
//   result    o_valid / i_ready    action, operands, mode flags, last marker
//   config    i_cfg_wr_en          node identifier
//
// A request is captured in an input register, decoded in one pass of combinational
// logic, and its result is loaded into the result register as soon as that register
// can take it. One request per cycle is sustained while the result side is ready; a
// request for all telemetry values holds the result register for its four replies,
// and that register sets the rate. Back pressure on the result side stalls the input
// register, which in turn drops o_ready. Reset is synchronous and active low: it clears
// both valid bits, the link and mode flags, and restores the node identifier to 0x123.
`default_nettype none

module motor_command_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [10:0] i_cfg_wr_data,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [10:0] i_frame_id,
    input  logic        i_extended,
    input  logic [3:0]  i_length,
    input  logic [7:0]  i_byte_0,
    input  logic [7:0]  i_byte_1,
    input  logic [7:0]  i_byte_2,
    input  logic [7:0]  i_byte_3,
    input  logic [7:0]  i_byte_4,
    input  logic [7:0]  i_byte_5,
    input  logic [7:0]  i_byte_6,
    input  logic [7:0]  i_byte_7,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_action,
    output logic [2:0]  o_param_select,
    output logic        o_direction,
    output logic [31:0] o_value,
    output logic [2:0]  o_reply_select,
    output logic        o_link_enabled,
    output logic        o_open_loop_on,
    output logic        o_pid_on,
    output logic        o_fuzzy_on,
    output logic        o_run_cw,
    output logic        o_run_ccw,
    output logic        o_last
);
    import mcfd_pkg::*;

    logic [10:0] r_node_id;
    t_flags      r_flags;
    t_flags      n_flags;
    t_item       r_item;
    logic        r_in_valid;
    t_result     dec_result;
    logic        load_ok;
    logic        move;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id <= NODE_ID_RESET;
        end else if (i_cfg_wr_en) begin
            r_node_id <= i_cfg_wr_data;
        end
    end

    // The decoded request moves into the result register when that register frees up.
    assign move    = r_in_valid && load_ok;
    assign o_ready = !r_in_valid || load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.mode     <= i_mode;
            r_item.frame_id <= i_frame_id;
            r_item.extended <= i_extended;
            r_item.length   <= i_length;
            r_item.data     <= {i_byte_7, i_byte_6, i_byte_5, i_byte_4,
                                i_byte_3, i_byte_2, i_byte_1, i_byte_0};
        end
    end

    // Flags advance only when a request is committed to the result register, so the
    // next request is always decoded against the state its predecessor left behind.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (move) begin
            r_flags <= n_flags;
        end
    end

    mcfd_decode u_decode (
        .i_item    (r_item),
        .i_flags   (r_flags),
        .i_node_id (r_node_id),
        .o_result  (dec_result),
        .o_flags   (n_flags)
    );

    mcfd_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (move),
        .i_result       (dec_result),
        .o_load_ok      (load_ok),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_action       (o_action),
        .o_param_select (o_param_select),
        .o_direction    (o_direction),
        .o_value        (o_value),
        .o_reply_select (o_reply_select),
        .o_link_enabled (o_link_enabled),
        .o_open_loop_on (o_open_loop_on),
        .o_pid_on       (o_pid_on),
        .o_fuzzy_on     (o_fuzzy_on),
        .o_run_cw       (o_run_cw),
        .o_run_ccw      (o_run_ccw),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

// ===== design/mcfd_checker.sv =====
// Port-level checks for the motor command frame decoder, bound to the top level.
`default_nettype none

module mcfd_port_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_action,
    input logic        o_open_loop_on,
    input logic        o_pid_on,
    input logic        o_fuzzy_on,
    input logic        o_run_cw,
    input logic        o_run_ccw,
    input logic        o_last
);
    import mcfd_pkg::*;

    // A pending result is not withdrawn.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // The control modes exclude one another.
    a_modes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0({o_open_loop_on, o_pid_on, o_fuzzy_on}))
        else $error("more than one control mode active");

    a_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_run_cw && o_run_ccw))
        else $error("both directions active");

    // Only telemetry replies come in bursts.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_action != ACT_REPLY) |-> o_last)
        else $error("non-reply result not marked last");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind motor_command_frame_decoder mcfd_port_props u_mcfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_action       (o_action),
    .o_open_loop_on (o_open_loop_on),
    .o_pid_on       (o_pid_on),
    .o_fuzzy_on     (o_fuzzy_on),
    .o_run_cw       (o_run_cw),
    .o_run_ccw      (o_run_ccw),
    .o_last         (o_last)
);

`default_nettype wire

// ===== verif/mcfd_checker.sv =====
// Result predictor and scoreboard for the motor command frame decoder.
module mcfd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [10:0] i_cfg_wr_data,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic        i_mode,
    input  logic [10:0] i_frame_id,
    input  logic        i_extended,
    input  logic [3:0]  i_length,
    input  logic [7:0]  i_byte_0,
    input  logic [7:0]  i_byte_1,
    input  logic [7:0]  i_byte_2,
    input  logic [7:0]  i_byte_3,
    input  logic [7:0]  i_byte_4,
    input  logic [7:0]  i_byte_5,
    input  logic [7:0]  i_byte_6,
    input  logic [7:0]  i_byte_7,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [2:0]  o_action,
    input  logic [2:0]  o_param_select,
    input  logic        o_direction,
    input  logic [31:0] o_value,
    input  logic [2:0]  o_reply_select,
    input  logic        o_link_enabled,
    input  logic        o_open_loop_on,
    input  logic        o_pid_on,
    input  logic        o_fuzzy_on,
    input  logic        o_run_cw,
    input  logic        o_run_ccw,
    input  logic        o_last,
    output int          o_mismatch_count,
    output int          o_pending,
    output int          o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import mcfd_pkg::*;

    typedef struct packed {
        t_action     action;
        logic [2:0]  param_select;
        logic        direction;
        logic [31:0] value;
        logic [2:0]  reply_select;
        t_flags      flags;
        logic        last;
    } t_decoded;

    logic [10:0] node_id_q = NODE_ID_RESET;
    t_flags      flags_q   = '0;
    t_decoded    predicted_results[$];
    int          failures     = 0;
    int          results_seen = 0;

    function automatic void push_result(input t_action act, input logic [2:0] psel,
                                        input logic dir, input logic [31:0] val,
                                        input logic [2:0] rsel, input logic fin);
        t_decoded e;
        e.action       = act;
        e.param_select = psel;
        e.direction    = dir;
        e.value        = val;
        e.reply_select = rsel;
        e.flags        = flags_q;
        e.last         = fin;
        predicted_results.push_back(e);
    endfunction

    function automatic logic is_word(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] c, input logic [7:0] x,
                                     input logic [7:0] y, input logic [7:0] z);
        return (a == x) && (b == y) && (c == z);
    endfunction

    // Works out the results of one request and updates the mode flags.
    function automatic void decode_request(input logic mode, input logic [10:0] fid,
                                           input logic ext, input logic [3:0] len,
                                           input logic [7:0][7:0] d);
        logic [7:0]  csum;
        logic [31:0] val;
        logic [2:0]  psel;
        logic [2:0]  rsel;
        logic        dir;
        logic        granted;
        logic        has_rsel;
        if (mode) begin
            // The clear request keeps the link flag.
            flags_q.open_loop = 1'b0;
            flags_q.pid       = 1'b0;
            flags_q.fuzzy     = 1'b0;
            flags_q.cw        = 1'b0;
            flags_q.ccw       = 1'b0;
            push_result(ACT_NONE, '0, 1'b0, '0, '0, 1'b1);
            return;
        end
        csum = 8'd0;
        for (int k = 0; k < 7; k++) csum = csum - d[k];
        if (fid != node_id_q || ext || len != FRAME_LEN || csum != d[7]) begin
            push_result(ACT_REJECT, '0, 1'b0, '0, '0, 1'b1);
            return;
        end
        val = {d[6], d[5], d[4], d[3]};
        if (is_word(d[0], d[1], d[2], CH_C, CH_A, CH_N)) begin
            if (d[3] == CH_O)
                flags_q.link = 1'b1;
            else if (d[3] == CH_C)
                flags_q.link = 1'b0;
        end
        if (!flags_q.link) begin
            push_result(ACT_NONE, '0, 1'b0, '0, '0, 1'b1);
            return;
        end
        dir = (d[2] == CH_L);
        if (d[0] == CH_O && d[1] == CH_L && (d[2] == CH_R || d[2] == CH_L)) begin
            flags_q.cw  = !dir;
            flags_q.ccw = dir;
            if (!flags_q.pid && !flags_q.fuzzy) begin
                flags_q.open_loop = 1'b1;
                push_result(ACT_DRIVE, '0, dir, val, '0, 1'b1);
            end else begin
                push_result(ACT_NONE, '0, 1'b0, '0, '0, 1'b1);
            end
            return;
        end
        if (d[0] == CH_C && (d[1] == CH_P || d[1] == CH_F) &&
            (d[2] == CH_R || d[2] == CH_L)) begin
            flags_q.cw  = !dir;
            flags_q.ccw = dir;
            if (d[1] == CH_P) begin
                granted = !flags_q.open_loop && !flags_q.fuzzy;
                if (granted) flags_q.pid = 1'b1;
            end else begin
                granted = !flags_q.open_loop && !flags_q.pid;
                if (granted) flags_q.fuzzy = 1'b1;
            end
            if (granted)
                push_result(ACT_SETPOINT, PSEL_SETPOINT, dir, val, '0, 1'b1);
            else
                push_result(ACT_NONE, '0, 1'b0, '0, '0, 1'b1);
            return;
        end
        case ({d[0], d[1], d[2]})
            {CH_G, CH_K, CH_P}: psel = PSEL_KP;
            {CH_G, CH_K, CH_I}: psel = PSEL_KI;
            {CH_G, CH_K, CH_D}: psel = PSEL_KD;
            {CH_G, CH_G, CH_E}: psel = PSEL_GE;
            {CH_G, CH_D, CH_E}: psel = PSEL_GDE;
            {CH_G, CH_D, CH_U}: psel = PSEL_GDU;
            default:            psel = PSEL_SETPOINT;
        endcase
        if (psel != PSEL_SETPOINT) begin
            push_result(ACT_GAIN, psel, 1'b0, val, '0, 1'b1);
            return;
        end
        if (is_word(d[0], d[1], d[2], CH_R, CH_E, CH_Q) && d[6] == TERMINATOR) begin
            has_rsel = 1'b1;
            rsel     = RSEL_SPEED;
            case ({d[3], d[4], d[5]})
                {CH_A, CH_L, CH_L}: begin
                    push_result(ACT_REPLY, '0, 1'b0, '0, RSEL_SPEED, 1'b0);
                    push_result(ACT_REPLY, '0, 1'b0, '0, RSEL_SENSOR_T, 1'b0);
                    push_result(ACT_REPLY, '0, 1'b0, '0, RSEL_CURRENT, 1'b0);
                    push_result(ACT_REPLY, '0, 1'b0, '0, RSEL_DUTY, 1'b1);
                    return;
                end
                {CH_R, CH_P, CH_V}: rsel = RSEL_SPEED;
                {CH_A, CH_O, CH_C}: rsel = RSEL_CHIP_T;
                {CH_A, CH_T, CH_K}: rsel = RSEL_SENSOR_T;
                {CH_A, CH_I, CH_M}: rsel = RSEL_CURRENT;
                {CH_T, CH_D, CH_C}: rsel = RSEL_DUTY;
                {CH_R, CH_S, CH_P}: rsel = RSEL_SETPOINT;
                default:            has_rsel = 1'b0;
            endcase
            if (has_rsel) begin
                push_result(ACT_REPLY, '0, 1'b0, '0, rsel, 1'b1);
                return;
            end
        end
        push_result(ACT_NONE, '0, 1'b0, '0, '0, 1'b1);
    endfunction

    always @(posedge i_clk) begin
        t_decoded exp_r;
        t_decoded got_r;
        if (!i_rst_n) begin
            node_id_q = NODE_ID_RESET;
            flags_q   = '0;
            predicted_results.delete();
        end else begin
            // Results are compared before new requests are predicted.
            if (o_valid && i_ready) begin
                results_seen++;
                got_r.action       = t_action'(o_action);
                got_r.param_select = o_param_select;
                got_r.direction    = o_direction;
                got_r.value        = o_value;
                got_r.reply_select = o_reply_select;
                got_r.flags        = {o_link_enabled, o_open_loop_on, o_pid_on,
                                      o_fuzzy_on, o_run_cw, o_run_ccw};
                got_r.last         = o_last;
                if (predicted_results.size() == 0) begin
                    if (failures < 10)
                        $display("%0t: result with nothing expected: act=%0d rsel=%0d last=%b",
                                 $realtime, got_r.action, got_r.reply_select, got_r.last);
                    failures++;
                end else begin
                    exp_r = predicted_results.pop_front();
                    if (exp_r.action !== got_r.action ||
                        exp_r.param_select !== got_r.param_select ||
                        exp_r.direction !== got_r.direction ||
                        exp_r.value !== got_r.value ||
                        exp_r.reply_select !== got_r.reply_select ||
                        exp_r.flags !== got_r.flags ||
                        exp_r.last !== got_r.last) begin
                        if (failures < 10) begin
                            $display("%0t: mismatch, expected act=%0d psel=%0d dir=%b val=%h rsel=%0d flags=%b last=%b",
                                     $realtime, exp_r.action, exp_r.param_select,
                                     exp_r.direction, exp_r.value, exp_r.reply_select,
                                     exp_r.flags, exp_r.last);
                            $display("%0t: mismatch, actual   act=%0d psel=%0d dir=%b val=%h rsel=%0d flags=%b last=%b",
                                     $realtime, got_r.action, got_r.param_select,
                                     got_r.direction, got_r.value, got_r.reply_select,
                                     got_r.flags, got_r.last);
                        end
                        failures++;
                    end
                end
            end
            if (i_cfg_wr_en)
                node_id_q = i_cfg_wr_data;
            if (i_valid && o_ready)
                decode_request(i_mode, i_frame_id, i_extended, i_length,
                               {i_byte_7, i_byte_6, i_byte_5, i_byte_4,
                                i_byte_3, i_byte_2, i_byte_1, i_byte_0});
        end
        o_mismatch_count <= failures;
        o_pending        <= predicted_results.size();
        o_result_count   <= results_seen;
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the motor command frame decoder: stimulus, pacing and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mcfd_pkg::*;

    // The run is cut off here; the slowest legal run needs a small fraction of it.
    localparam int CYCLE_LIMIT = 200000;
    // Length of the long result-side stall that backs the block up.
    localparam int HOLD_CYCLES = 80;

    // Gain words, bytes 1 and 2 after the leading G; index 0 is kp.
    localparam logic [5:0][15:0] GAIN_WORDS = {
        {CH_D, CH_U}, {CH_D, CH_E}, {CH_G, CH_E},
        {CH_K, CH_D}, {CH_K, CH_I}, {CH_K, CH_P}
    };
    // Telemetry request words, bytes 3 to 5; index 0 is speed, index 6 asks for all.
    localparam logic [6:0][23:0] REPLY_WORDS = {
        {CH_A, CH_L, CH_L}, {CH_R, CH_S, CH_P}, {CH_T, CH_D, CH_C},
        {CH_A, CH_I, CH_M}, {CH_A, CH_T, CH_K}, {CH_A, CH_O, CH_C},
        {CH_R, CH_P, CH_V}
    };
    // Letters that appear in the command words, used to build near misses.
    localparam logic [14:0][7:0] LETTERS = {
        CH_C, CH_A, CH_N, CH_O, CH_L, CH_R, CH_P, CH_F,
        CH_G, CH_K, CH_I, CH_D, CH_E, CH_U, CH_Q
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [10:0] i_cfg_wr_data = '0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic        i_mode        = 1'b0;
    logic [10:0] i_frame_id    = '0;
    logic        i_extended    = 1'b0;
    logic [3:0]  i_length      = '0;
    logic [7:0]  i_byte_0      = '0;
    logic [7:0]  i_byte_1      = '0;
    logic [7:0]  i_byte_2      = '0;
    logic [7:0]  i_byte_3      = '0;
    logic [7:0]  i_byte_4      = '0;
    logic [7:0]  i_byte_5      = '0;
    logic [7:0]  i_byte_6      = '0;
    logic [7:0]  i_byte_7      = '0;
    logic        o_valid;
    logic        i_ready       = 1'b0;
    logic [2:0]  o_action;
    logic [2:0]  o_param_select;
    logic        o_direction;
    logic [31:0] o_value;
    logic [2:0]  o_reply_select;
    logic        o_link_enabled;
    logic        o_open_loop_on;
    logic        o_pid_on;
    logic        o_fuzzy_on;
    logic        o_run_cw;
    logic        o_run_ccw;
    logic        o_last;
    int          o_mismatch_count;
    int          o_pending;
    int          o_result_count;

    // Pacing knobs: percent of cycles in which each side idles.
    int          tx_idle_pct = 24;
    int          rx_idle_pct = 48;
    // Toggling this asks the receiver process for one long stall.
    logic        hold_toggle = 1'b0;
    logic        hold_seen   = 1'b0;
    int          stall_left  = 0;
    int          cycle_count = 0;
    int          requests_sent = 0;
    // Node identifier the stimulus currently addresses; it tracks each write.
    logic [10:0] cur_node = NODE_ID_RESET;
    logic [10:0] last_node;

    motor_command_frame_decoder uut (.*);

    mcfd_checker checker_i (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side. Between long stalls the ready line is drawn at random with the
    // current idle rate; a long stall is counted down here, so the sender keeps
    // offering requests while the block backs up and drops o_ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left = 0;
            hold_seen  = hold_toggle;
        end else if (hold_toggle != hold_seen) begin
            hold_seen  = hold_toggle;
            stall_left = HOLD_CYCLES;
            i_ready    <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Builds a well-formed frame for the current node: standard identifier, length
    // eight, and byte 7 set so that all eight bytes sum to zero.
    function automatic t_item make_frame(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [31:0] val);
        t_item      r;
        logic [7:0] csum;
        r.mode     = 1'b0;
        r.frame_id = cur_node;
        r.extended = 1'b0;
        r.length   = FRAME_LEN;
        r.data[0]  = b0;
        r.data[1]  = b1;
        r.data[2]  = b2;
        r.data[3]  = val[7:0];
        r.data[4]  = val[15:8];
        r.data[5]  = val[23:16];
        r.data[6]  = val[31:24];
        csum = 8'd0;
        for (int k = 0; k < 7; k++) csum = csum - r.data[k];
        r.data[7] = csum;
        return r;
    endfunction

    // A clear request; the frame fields ride along with random content.
    function automatic t_item clear_request();
        t_item r;
        r.mode     = 1'b1;
        r.frame_id = 11'($urandom);
        r.extended = 1'($urandom);
        r.length   = 4'($urandom);
        r.data     = {$urandom(), $urandom()};
        return r;
    endfunction

    // One well-formed command word with random operands; a telemetry request may lack its terminator.
    function automatic t_item well_formed_command();
        logic [31:0] val;
        logic [23:0] req;
        logic [7:0]  term;
        logic [7:0]  side;
        int          pick;
        val  = $urandom();
        pick = $urandom_range(99);
        side = ($urandom_range(1) == 1) ? CH_L : CH_R;
        if (pick < 9)
            return make_frame(CH_C, CH_A, CH_N, {val[31:8], CH_O});
        if (pick < 13)
            return make_frame(CH_C, CH_A, CH_N, {val[31:8], CH_C});
        if (pick < 30)
            return make_frame(CH_O, CH_L, side, val);
        if (pick < 52)
            return make_frame(CH_C, ($urandom_range(1) == 1) ? CH_P : CH_F, side, val);
        if (pick < 74) begin
            req[15:0] = GAIN_WORDS[$urandom_range(5)];
            return make_frame(CH_G, req[15:8], req[7:0], val);
        end
        req = REPLY_WORDS[$urandom_range(6)];
        if ($urandom_range(3) == 0) req = REPLY_WORDS[6];
        // Now and then the terminator is missing.
        term = ($urandom_range(9) == 0) ? val[31:24] : TERMINATOR;
        return make_frame(CH_R, CH_E, CH_Q, {term, req[7:0], req[15:8], req[23:16]});
    endfunction

    // Random mix: mostly valid commands, plus clear requests, near-miss words,
    // random payloads and frames broken in one header or checksum field.
    function automatic t_item random_request();
        t_item       r;
        logic [31:0] val;
        int          pick;
        pick = $urandom_range(99);
        val  = $urandom();
        if (pick < 8)
            return clear_request();
        if (pick < 72)
            return well_formed_command();
        if (pick < 80) begin
            if ($urandom_range(1) == 1)
                val = {TERMINATOR, LETTERS[$urandom_range(14)],
                       LETTERS[$urandom_range(14)], LETTERS[$urandom_range(14)]};
            return make_frame(LETTERS[$urandom_range(14)], LETTERS[$urandom_range(14)],
                              LETTERS[$urandom_range(14)], val);
        end
        if (pick < 86)
            return make_frame(8'($urandom), 8'($urandom), 8'($urandom), val);
        r = well_formed_command();
        case ($urandom_range(3))
            0:       r.frame_id = cur_node ^ 11'($urandom_range(1, 2047));
            1:       r.extended = 1'b1;
            2:       r.length   = FRAME_LEN ^ 4'($urandom_range(1, 15));
            default: r.data[7]  = r.data[7] ^ 8'($urandom_range(1, 255));
        endcase
        return r;
    endfunction

    // Offers one request and returns at the edge where it is taken. Valid stays
    // high into the next request unless the sender decides to idle first.
    task automatic send_request(input t_item r);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_mode     <= r.mode;
        i_frame_id <= r.frame_id;
        i_extended <= r.extended;
        i_length   <= r.length;
        i_byte_0   <= r.data[0];
        i_byte_1   <= r.data[1];
        i_byte_2   <= r.data[2];
        i_byte_3   <= r.data[3];
        i_byte_4   <= r.data[4];
        i_byte_5   <= r.data[5];
        i_byte_6   <= r.data[6];
        i_byte_7   <= r.data[7];
        i_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        requests_sent++;
    endtask

    task automatic send_cmd(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [31:0] val);
        send_request(make_frame(b0, b1, b2, val));
    endtask

    // Stops offering and waits until every predicted result has come back. The
    // pending count is registered, hence the first wait.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (o_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Node identifier writes happen only with the block drained.
    task automatic write_node_id(input logic [10:0] id);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= id;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_node = id;
        @(posedge i_clk);
    endtask

    task automatic random_burst(input int count);
        for (int k = 0; k < count; k++) send_request(random_request());
    endtask

    // Directed opening: header rejects, the mode conflicts, every gain and
    // telemetry word, requests without terminator, and the link turned off.
    task automatic directed_checks();
        t_item r;
        logic [23:0] req;
        send_request(clear_request());
        send_cmd(CH_C, CH_A, CH_N, {24'h0, CH_O});
        r = make_frame(CH_C, CH_A, CH_N, {24'h0, CH_O});
        r.data[7] = r.data[7] + 8'd1;
        send_request(r);
        r = make_frame(CH_G, CH_K, CH_P, 32'h1234_5678);
        r.frame_id = cur_node ^ 11'h7FF;
        send_request(r);
        r = make_frame(CH_G, CH_K, CH_P, 32'h1234_5678);
        r.extended = 1'b1;
        send_request(r);
        r = make_frame(CH_G, CH_K, CH_P, 32'h1234_5678);
        r.length = 4'hF;
        send_request(r);
        // Open loop with the largest operand, then a closed-loop word blocked by it.
        send_cmd(CH_O, CH_L, CH_R, 32'hFFFF_FFFF);
        send_cmd(CH_C, CH_P, CH_R, 32'hA5A5_A5A5);
        send_request(clear_request());
        send_cmd(CH_C, CH_P, CH_L, 32'h0000_0000);
        send_cmd(CH_C, CH_F, CH_R, 32'h5A5A_5A5A);
        send_cmd(CH_O, CH_L, CH_L, 32'h0F0F_0F0F);
        send_request(clear_request());
        send_cmd(CH_C, CH_F, CH_L, 32'h8000_0001);
        for (int k = 0; k < 6; k++) begin
            req[15:0] = GAIN_WORDS[k];
            send_cmd(CH_G, req[15:8], req[7:0], $urandom());
        end
        for (int k = 6; k >= 0; k--) begin
            req = REPLY_WORDS[k];
            send_cmd(CH_R, CH_E, CH_Q, {TERMINATOR, req[7:0], req[15:8], req[23:16]});
        end
        send_cmd(CH_R, CH_E, CH_Q, {8'h00, CH_V, CH_P, CH_R});
        send_cmd(CH_R, CH_E, CH_Q, {TERMINATOR, CH_Q, CH_Q, CH_Q});
        send_cmd(CH_C, CH_A, CH_N, {24'hFFFFFF, CH_C});
        send_cmd(CH_G, CH_K, CH_I, 32'h0BAD_F00D);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles lightly, receiver heavily; node id at its reset value.
        directed_checks();
        random_burst(60);

        // Long result stall while the sender keeps pushing without gaps.
        hold_toggle <= ~hold_toggle;
        tx_idle_pct = 0;
        random_burst(14);
        tx_idle_pct = 24;
        // Full pause of the sender until the block has emptied.
        drain_results();
        random_burst(50);
        drain_results();

        // Roles swapped, node id at its top value.
        write_node_id(11'h7FF);
        tx_idle_pct = 48;
        rx_idle_pct <= 24;
        random_burst(110);
        drain_results();

        // No idling on either side, node id zero, then a random one.
        write_node_id(11'h000);
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        random_burst(60);
        drain_results();
        last_node = 11'($urandom_range(2047));
        write_node_id(last_node);
        random_burst(60);
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d requests and %0d results: commands, clear requests, broken frames",
                 requests_sent, o_result_count);
        $display("Node ids 123, 7ff, 000 and %03h; light, heavy and no idling; long result stall",
                 last_node);
        if (o_mismatch_count == 0 && o_pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
